// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the keyframe spline evaluator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define KSES_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition leads to a consequence in the next cycle
`define KSES_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/kses_pkg.sv -----
// ----------------------------------------------------------------------------
// kses_pkg
// Shared constants and types of the keyframe spline evaluator.
// ----------------------------------------------------------------------------
package kses_pkg;

	localparam int MAX_KEYS_DEF  = 64;
	localparam int NUM_DIMS_DEF  = 4;
	localparam int FRAC_BITS_DEF = 16;

	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_W       = 7;
	localparam int SEG_W       = 7;
	localparam int MUL_W       = 64;
	localparam int DT_BITS     = 33;
	localparam int STEP_W      = 6;
	localparam int Q_DEPTH     = 2;

	typedef struct packed {
		logic               is_eval;
		logic               wr_ok;
		logic               dim_ok;
		logic [5:0]         point_index;
		logic [1:0]         dimension;
		logic signed [31:0] time_req;
		logic signed [31:0] point_value;
		logic signed [31:0] slope_before;
		logic signed [31:0] slope_after;
		logic               linear_flag;
	} cmd_t;

	typedef struct packed {
		logic [1:0] count;
		logic       full;
	} q_stat_t;

endpackage

// ----- hdl/kses_front.sv -----
// ----------------------------------------------------------------------------
// kses_front
// Input stage: accepts words, classifies them and offers them to the queue.
// ----------------------------------------------------------------------------
module kses_front #(
	parameter int MAX_KEYS = kses_pkg::MAX_KEYS_DEF,
	parameter int NUM_DIMS = kses_pkg::NUM_DIMS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [kses_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tuser,
	output logic                             f_valid,
	input  logic                             f_ready,
	output kses_pkg::cmd_t                   f_data
);
	import kses_pkg::*;

	logic vld_s1;
	cmd_t cmd_s1;
	cmd_t dec;

	always_comb begin
		dec.is_eval      = s_tuser;
		dec.point_index  = s_tdata[5:0];
		dec.dimension    = s_tdata[7:6];
		dec.time_req     = $signed(s_tdata[39:8]);
		dec.point_value  = $signed(s_tdata[71:40]);
		dec.slope_before = $signed(s_tdata[103:72]);
		dec.slope_after  = $signed(s_tdata[135:104]);
		dec.linear_flag  = s_tdata[136];
		dec.dim_ok       = (32'(s_tdata[7:6]) < 32'(NUM_DIMS));
		dec.wr_ok        = (32'(s_tdata[5:0]) < 32'(MAX_KEYS)) && dec.dim_ok;
	end

	assign s_tready = !vld_s1 || f_ready;
	assign f_valid  = vld_s1;
	assign f_data   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cmd_s1 <= '0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
			cmd_s1 <= dec;
		end else if (f_ready) begin
			vld_s1 <= 1'b0;
		end
	end

endmodule

// ----- hdl/kses_queue.sv -----
// ----------------------------------------------------------------------------
// kses_queue
// Two-entry command queue between the input stage and the execution engine.
// ----------------------------------------------------------------------------
module kses_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  kses_pkg::cmd_t     in_data,
	output logic               out_valid,
	input  logic               out_pop,
	output kses_pkg::cmd_t     out_data,
	output kses_pkg::q_stat_t  stat
);
	import kses_pkg::*;

	cmd_t       ent_q [Q_DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign stat.count = cnt_q;
	assign stat.full  = (cnt_q == 2'(Q_DEPTH));
	assign in_ready   = !stat.full;
	assign out_valid  = (cnt_q != 2'd0);
	assign out_data   = ent_q[rd_q];
	assign push       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (out_pop)
				rd_q <= !rd_q;
			if (push && !out_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!push && out_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= in_data;
	end

endmodule

// ----- hdl/kses_mulq.sv -----
// ----------------------------------------------------------------------------
// kses_mulq
// Shift-add multiplier: trunc(x * y / 2^FRAC_BITS), one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module kses_mulq #(
	parameter int FRAC_BITS = kses_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [kses_pkg::MUL_W-1:0]     x,
	input  logic [kses_pkg::DT_BITS-1:0]          y,
	input  logic [kses_pkg::STEP_W-1:0]           steps,
	output logic                                  done,
	output logic signed [kses_pkg::MUL_W-1:0]     result
);
	import kses_pkg::*;

	localparam int PW = MUL_W + DT_BITS;

	logic [PW-1:0]      mcand_q;
	logic [PW-1:0]      acc_q;
	logic [DT_BITS-1:0] y_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               neg_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_W-1:0]   mag;
	logic [PW-1:0]      shifted;
	logic [MUL_W-1:0]   mag_r;

	assign mag     = x[MUL_W-1] ? MUL_W'(-x) : MUL_W'(x);
	assign shifted = acc_q >> FRAC_BITS;
	assign mag_r   = shifted[MUL_W-1:0];
	assign result  = neg_q ? -$signed(mag_r) : $signed(mag_r);
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			mcand_q <= '0;
			acc_q   <= '0;
			y_q     <= '0;
			neg_q   <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == STEP_W'(1));
			if (start) begin
				mcand_q <= PW'(mag);
				acc_q   <= '0;
				y_q     <= y;
				cnt_q   <= steps;
				neg_q   <= x[MUL_W-1];
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				if (y_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q <= mcand_q << 1;
				y_q     <= y_q >> 1;
				cnt_q   <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/kses_back.sv -----
// ----------------------------------------------------------------------------
// kses_back
// Execution engine: keyframe storage, segment search, divide and Hermite eval.
// ----------------------------------------------------------------------------
module kses_back #(
	parameter int MAX_KEYS  = kses_pkg::MAX_KEYS_DEF,
	parameter int NUM_DIMS  = kses_pkg::NUM_DIMS_DEF,
	parameter int FRAC_BITS = kses_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kses_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             q_valid,
	input  kses_pkg::cmd_t                   q_data,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [kses_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import kses_pkg::*;

	localparam int IW  = $clog2(MAX_KEYS);
	localparam int VD  = MAX_KEYS * NUM_DIMS;
	localparam int VW  = $clog2(VD);
	localparam int EPS = (1 << FRAC_BITS) / 10000;
	localparam int DCW = $clog2(FRAC_BITS + 1);

	typedef enum logic [14:0] {
		ST_IDLE    = 15'b000000000000001,
		ST_FWD_RD  = 15'b000000000000010,
		ST_FWD_CMP = 15'b000000000000100,
		ST_BK_RD   = 15'b000000000001000,
		ST_BK_CMP  = 15'b000000000010000,
		ST_SEL     = 15'b000000000100000,
		ST_ONE     = 15'b000000001000000,
		ST_RD0     = 15'b000000010000000,
		ST_RD1     = 15'b000000100000000,
		ST_RD2     = 15'b000001000000000,
		ST_CALC    = 15'b000010000000000,
		ST_DIV     = 15'b000100000000000,
		ST_MSTART  = 15'b001000000000000,
		ST_MWAIT   = 15'b010000000000000,
		ST_OUT     = 15'b100000000000000
	} state_t;

	typedef enum logic [5:0] {
		PH_LIN = 6'b000001,
		PH_PA  = 6'b000010,
		PH_PB  = 6'b000100,
		PH_ED  = 6'b001000,
		PH_ACC = 6'b010000,
		PH_FIN = 6'b100000
	} phase_t;

	logic [32:0]        tmem  [MAX_KEYS];
	logic signed [31:0] vmem  [VD];
	logic signed [31:0] samem [VD];
	logic signed [31:0] sbmem [VD];

	state_t                  state_q;
	phase_t                  ph_q;
	cmd_t                    cur_q;
	logic [CFG_W-1:0]        pc_q;
	logic [IW:0]             p_q;
	logic [IW:0]             cache_q;
	logic [32:0]             rd_t_q;
	logic signed [31:0]      rd_v_q;
	logic signed [31:0]      rd_sa_q;
	logic signed [31:0]      rd_sb_q;
	logic signed [31:0]      t0_q;
	logic signed [31:0]      t1_q;
	logic signed [31:0]      v0_q;
	logic signed [31:0]      v1_q;
	logic signed [31:0]      sa_q;
	logic signed [31:0]      sb_q;
	logic                    lin_q;
	logic signed [32:0]      dt_q;
	logic [33:0]             rem_q;
	logic [FRAC_BITS-1:0]    ft_q;
	logic [DCW-1:0]          dcnt_q;
	logic signed [MUL_W-1:0] pa_q;
	logic signed [MUL_W-1:0] ec_q;
	logic signed [MUL_W-1:0] acc_q;
	logic signed [31:0]      res_q;
	logic                    out_valid_q;
	logic signed [31:0]      out_val_q;
	logic [SEG_W-1:0]        out_seg_q;

	logic [IW:0]             cnt_w;
	logic                    has_next;
	logic [IW-1:0]           pm1;
	logic [IW-1:0]           pk;
	logic [IW-1:0]           t_raddr;
	logic [VW-1:0]           v_raddr;
	logic [VW-1:0]           sa_raddr;
	logic [VW-1:0]           sb_raddr;
	logic                    wr_en;
	logic [IW-1:0]           w_key;
	logic [VW-1:0]           w_vaddr;
	logic signed [31:0]      rd_time;
	logic signed [32:0]      dt_c;
	logic signed [32:0]      num_c;
	logic signed [32:0]      dv;
	logic signed [MUL_W-1:0] dv64;
	logic [33:0]             r2;
	logic                    ge;
	logic                    mul_start;
	logic signed [MUL_W-1:0] mul_x;
	logic [DT_BITS-1:0]      mul_y;
	logic [STEP_W-1:0]       mul_steps;
	logic                    mul_done;
	logic signed [MUL_W-1:0] mul_r;
	logic signed [IW+1:0]    seg_i;
	logic [IW:0]             p_start;

	function automatic logic [VW-1:0] vaddr(input logic [IW-1:0] k, input logic [1:0] d);
		vaddr = VW'(32'(k) * NUM_DIMS + 32'(d));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [MUL_W-1:0] v);
		if (v > MUL_W'(64'sd2147483647))
			sat32 = 32'sh7FFFFFFF;
		else if (v < -MUL_W'(64'sd2147483648))
			sat32 = 32'sh80000000;
		else
			sat32 = 32'(v);
	endfunction

	assign cnt_w    = (32'(pc_q) > 32'(MAX_KEYS)) ? (IW+1)'(MAX_KEYS) : (IW+1)'(pc_q);
	assign has_next = p_q < cnt_w;
	assign pm1      = IW'(p_q - 1'b1);
	assign pk       = IW'(p_q);
	assign p_start  = (cache_q > cnt_w) ? '0 : cache_q;
	assign rd_time  = $signed(rd_t_q[31:0]);
	assign dt_c     = 33'(t1_q) - 33'(t0_q);
	assign num_c    = 33'(cur_q.time_req) - 33'(t0_q);
	assign dv       = 33'(v1_q) - 33'(v0_q);
	assign dv64     = MUL_W'(dv);
	assign r2       = {rem_q[32:0], 1'b0};
	assign ge       = r2 >= {1'b0, dt_q};
	assign seg_i    = $signed((IW+2)'(p_q)) - $signed((IW+2)'(1));

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign wr_en    = q_pop && !q_data.is_eval && q_data.wr_ok;
	assign w_key    = IW'(q_data.point_index);
	assign w_vaddr  = vaddr(w_key, q_data.dimension);
	assign sa_raddr = vaddr(pm1, cur_q.dimension);
	assign sb_raddr = vaddr(pk, cur_q.dimension);

	always_comb begin
		t_raddr = '0;
		v_raddr = '0;
		case (state_q)
			ST_FWD_RD: t_raddr = pk;
			ST_BK_RD:  t_raddr = pm1;
			ST_SEL:    v_raddr = vaddr((p_q != '0) ? pm1 : '0, cur_q.dimension);
			ST_RD0: begin
				t_raddr = pm1;
				v_raddr = vaddr(pm1, cur_q.dimension);
			end
			ST_RD1: begin
				t_raddr = pk;
				v_raddr = vaddr(pk, cur_q.dimension);
			end
			default: begin
				t_raddr = '0;
				v_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tmem[w_key]    <= {q_data.linear_flag, q_data.time_req};
			vmem[w_vaddr]  <= q_data.point_value;
			samem[w_vaddr] <= q_data.slope_after;
			sbmem[w_vaddr] <= q_data.slope_before;
		end
		rd_t_q  <= tmem[t_raddr];
		rd_v_q  <= vmem[v_raddr];
		rd_sa_q <= samem[sa_raddr];
		rd_sb_q <= sbmem[sb_raddr];
	end

	assign mul_start = (state_q == ST_MSTART);

	always_comb begin
		case (ph_q)
			PH_LIN: begin
				mul_x     = dv64;
				mul_y     = DT_BITS'(ft_q);
				mul_steps = STEP_W'(FRAC_BITS);
			end
			PH_PA: begin
				mul_x     = MUL_W'(sa_q);
				mul_y     = DT_BITS'(dt_q);
				mul_steps = STEP_W'(DT_BITS);
			end
			PH_PB: begin
				mul_x     = MUL_W'(sb_q);
				mul_y     = DT_BITS'(dt_q);
				mul_steps = STEP_W'(DT_BITS);
			end
			default: begin
				mul_x     = acc_q;
				mul_y     = DT_BITS'(ft_q);
				mul_steps = STEP_W'(FRAC_BITS);
			end
		endcase
	end

	kses_mulq #(
		.FRAC_BITS(FRAC_BITS)
	) u_mulq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.steps  (mul_steps),
		.done   (mul_done),
		.result (mul_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= PH_LIN;
			cur_q       <= '0;
			pc_q        <= '0;
			p_q         <= '0;
			cache_q     <= (IW+1)'(1);
			t0_q        <= '0;
			t1_q        <= '0;
			v0_q        <= '0;
			v1_q        <= '0;
			sa_q        <= '0;
			sb_q        <= '0;
			lin_q       <= 1'b0;
			dt_q        <= '0;
			rem_q       <= '0;
			ft_q        <= '0;
			dcnt_q      <= '0;
			pa_q        <= '0;
			ec_q        <= '0;
			acc_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_val_q   <= '0;
			out_seg_q   <= '0;
		end else begin
			if (cfg_we)
				pc_q <= cfg_wdata;
			if (out_valid_q && m_tready && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q <= q_data;
						if (q_data.is_eval) begin
							p_q     <= p_start;
							state_q <= ST_FWD_RD;
						end
					end
				end
				ST_FWD_RD: state_q <= has_next ? ST_FWD_CMP : ST_BK_RD;
				ST_FWD_CMP: begin
					if (rd_time <= cur_q.time_req) begin
						p_q     <= p_q + 1'b1;
						state_q <= ST_FWD_RD;
					end else begin
						state_q <= ST_BK_RD;
					end
				end
				ST_BK_RD: state_q <= (p_q != '0) ? ST_BK_CMP : ST_SEL;
				ST_BK_CMP: begin
					if (rd_time > cur_q.time_req) begin
						p_q     <= p_q - 1'b1;
						state_q <= ST_BK_RD;
					end else begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					cache_q <= p_q;
					if (!cur_q.dim_ok || cnt_w == '0) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else if (p_q != '0 && has_next) begin
						state_q <= ST_RD0;
					end else begin
						state_q <= ST_ONE;
					end
				end
				ST_ONE: begin
					res_q   <= rd_v_q;
					state_q <= ST_OUT;
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: begin
					t0_q    <= rd_time;
					lin_q   <= rd_t_q[32];
					v0_q    <= rd_v_q;
					sa_q    <= rd_sa_q;
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					t1_q    <= rd_time;
					v1_q    <= rd_v_q;
					sb_q    <= rd_sb_q;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					dt_q <= dt_c;
					ph_q <= lin_q ? PH_LIN : PH_PA;
					if (dt_c <= $signed(33'(EPS))) begin
						res_q   <= v0_q;
						state_q <= ST_OUT;
					end else if (num_c >= dt_c) begin
						ft_q    <= '1;
						state_q <= ST_MSTART;
					end else begin
						rem_q   <= 34'(num_c);
						ft_q    <= '0;
						dcnt_q  <= DCW'(FRAC_BITS);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= ge ? (r2 - {1'b0, dt_q}) : r2;
					ft_q   <= {ft_q[FRAC_BITS-2:0], ge};
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DCW'(1))
						state_q <= ST_MSTART;
				end
				ST_MSTART: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (mul_done) begin
						case (ph_q)
							PH_LIN: begin
								res_q   <= sat32(MUL_W'(v0_q) + mul_r);
								state_q <= ST_OUT;
							end
							PH_PA: begin
								pa_q    <= mul_r;
								ph_q    <= PH_PB;
								state_q <= ST_MSTART;
							end
							PH_PB: begin
								ec_q    <= (dv64 <<< 1) + dv64 - (pa_q <<< 1) - mul_r;
								acc_q   <= pa_q + mul_r - (dv64 <<< 1);
								ph_q    <= PH_ED;
								state_q <= ST_MSTART;
							end
							PH_ED: begin
								acc_q   <= ec_q + mul_r;
								ph_q    <= PH_ACC;
								state_q <= ST_MSTART;
							end
							PH_ACC: begin
								acc_q   <= pa_q + mul_r;
								ph_q    <= PH_FIN;
								state_q <= ST_MSTART;
							end
							default: begin
								res_q   <= sat32(MUL_W'(v0_q) + mul_r);
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_val_q   <= res_q;
						out_seg_q   <= SEG_W'(seg_i);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - SEG_W - 32)'(0), out_seg_q, out_val_q};

endmodule

// ----- hdl/keyframe_spline_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// keyframe_spline_evaluator_top
// Keyframe table with segment search and linear or cubic Hermite evaluation.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input words; s_tuser is 0 for a keyframe write, 1 for an
//   evaluate. A write stores one component of one keyframe and returns nothing.
//   An evaluate returns one word on m_*: curve value and found segment index.
//   cfg_we/cfg_wdata set the number of keyframes in use; write it while idle.
//   Words pass an input register and a two-entry queue before the engine
//   sees them, so the input keeps accepting while the engine works.
//   Per word the engine does: a write is stored as it is popped; an evaluate
//   searches the segment key by key and, inside a segment, runs a bit-serial
//   divide (skipped at or past the segment end) and shift-add multiplies on
//   the one shared multiplier: one for a linear segment, two over DT_BITS and
//   three over FRAC_BITS bits for a cubic one, in Q16.16 at default FRAC_BITS.
//   Reset clears the key count and sets the cached search position to 1; the
//   keyframe memories hold no data until written. No clearing pass is needed.
//   A stalled m_tready holds the result word and, once the queue fills, the
//   input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyframe_spline_evaluator_top #(
	parameter int MAX_KEYS  = kses_pkg::MAX_KEYS_DEF,
	parameter int NUM_DIMS  = kses_pkg::NUM_DIMS_DEF,
	parameter int FRAC_BITS = kses_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kses_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// point_index[5:0], dimension[7:6], time_req[39:8], point_value[71:40],
	// slope_before[103:72], slope_after[135:104], linear_flag[136]
	input  logic [kses_pkg::IN_TDATA_W-1:0]  s_tdata,
	// op[0]
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// curve_value[31:0], segment_index[38:32]
	output logic [kses_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import kses_pkg::*;

	logic    f_valid;
	logic    q_ready;
	cmd_t    f_data;
	logic    q_valid;
	logic    q_pop;
	cmd_t    q_data;
	q_stat_t q_stat;
	logic    q_push;

	assign q_push = f_valid && q_ready;

	kses_front #(
		.MAX_KEYS(MAX_KEYS),
		.NUM_DIMS(NUM_DIMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.f_valid  (f_valid),
		.f_ready  (q_ready),
		.f_data   (f_data)
	);

	kses_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (q_ready),
		.in_data   (f_data),
		.out_valid (q_valid),
		.out_pop   (q_pop),
		.out_data  (q_data),
		.stat      (q_stat)
	);

	kses_back #(
		.MAX_KEYS (MAX_KEYS),
		.NUM_DIMS (NUM_DIMS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	`KSES_CHECK(a_pop_nonempty, q_pop |-> q_valid, "engine popped an empty queue")
	`KSES_CHECK(a_stall_full, !s_tready |-> q_stat.full, "input stalled with queue room")
	`KSES_CHECK_NEXT(a_q_grow, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 2'd1, "queue count lost a push")
	`KSES_CHECK_NEXT(a_q_shrink, !q_push && q_pop, q_stat.count == $past(q_stat.count) - 2'd1, "queue count lost a pop")

endmodule
